>>> sv/shosc_pkg.sv
// Shared constants, codes and helpers for the smoothed harmonic oscillator.
package shosc_pkg;

    localparam int HARMONICS_MAX_DEF   = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int AMP_W       = 16;
    localparam int RATE_W      = 16;
    localparam int PHASE_W     = 16;
    localparam int COUNT_W     = 5;
    localparam int STEP_W      = 16;
    localparam int OUT_W       = 24;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_AMPLITUDE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_RATE      = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_PHASE     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HARMONIC_COUNT   = 4'd3;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_PRESET = 1'b1;

    localparam logic [RATE_W-1:0]  RATE_RESET   = 16'd256;
    localparam logic [31:0]        SRATE_RESET  = 32'h0100_0000;
    localparam logic [COUNT_W-1:0] COUNT_RESET  = 5'd1;

    localparam int          GLIDE_DIV   = 100;
    localparam logic [31:0] GLIDE_RECIP = 32'hA3D7_0A3D;

    localparam logic [30:0]        Q30_ONE = 31'h4000_0000;
    localparam logic signed [31:0] POLY_C1 = 32'sd1686629713;
    localparam logic signed [31:0] POLY_C3 = 32'sd693598668;
    localparam logic signed [31:0] POLY_C5 = 32'sd85569306;
    localparam logic signed [31:0] POLY_C7 = 32'sd5026994;
    localparam logic signed [31:0] POLY_C9 = 32'sd172275;

    localparam int DIV_W     = 48;
    localparam int DIV_DIGIT = 4;

    localparam int OUT_MAX     = 8388607;
    localparam int OUT_MIN     = -8388608;
    localparam int ROUND_HALF  = 536870912;
    localparam int ROUND_SHIFT = 30;

    function automatic logic signed [31:0] poly_coef(input logic [1:0] k);
        logic signed [31:0] c;
        case (k)
            2'd0:    c = POLY_C7;
            2'd1:    c = POLY_C5;
            2'd2:    c = POLY_C3;
            default: c = POLY_C1;
        endcase
        return c;
    endfunction

endpackage

>>> sv/smoothed_harmonic_oscillator_core.sv
// Top level: gliding-parameter additive oscillator on one shared multiplier.
//
//  channel | ports                                         | dir | word
//  --------+-----------------------------------------------+-----+--------------------------
//  s_      | s_valid s_ready s_kind s_time_step s_preset_angle | in | tick or accumulator preset
//  m_      | m_valid m_ready m_position m_angle            | out | one word per tick
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data        | in  | target register write
//
//  A tick runs from acceptance to m_valid through the three glides, the accumulator update
//  and one pass for each harmonic up to the harmonic count after clamping.
//  Per harmonic the 33x33 multiplier runs two 6-product sine evaluations and two
//  amplitude products, and the 4-bit-per-cycle divider forms the 1/h scale.
//  A preset loads the accumulator. s_ready is high only between items; m_ready may stall.
//  Reset restores the targets, the glide values and the accumulator; cfg_ready stays high.
module smoothed_harmonic_oscillator_core #(
    parameter int HARMONICS_MAX   = shosc_pkg::HARMONICS_MAX_DEF,
    parameter int SINE_TABLE_BITS = shosc_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic [shosc_pkg::STEP_W-1:0]         s_time_step,
    input  logic [shosc_pkg::STEP_W-1:0]         s_preset_angle,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [shosc_pkg::OUT_W-1:0]   m_position,
    output logic signed [shosc_pkg::OUT_W-1:0]   m_angle,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [shosc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [shosc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int HB        = $clog2(HARMONICS_MAX + 1);
    localparam int SUM_W     = 48 + HB;
    localparam int OUT_W     = shosc_pkg::OUT_W;
    localparam int DIV_W     = shosc_pkg::DIV_W;
    localparam int DIV_STEPS = shosc_pkg::DIV_W / shosc_pkg::DIV_DIGIT;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [4:0] {
        ST_IDLE, ST_GLIDE_DIFF, ST_GLIDE_MUL, ST_GLIDE_FIX, ST_GLIDE_APPLY,
        ST_ACC_MUL, ST_ACC_ADD, ST_HARM_INIT, ST_SIN_SETUP, ST_SIN_SQ, ST_SIN_U2,
        ST_POLY_MUL, ST_POLY_SUB, ST_SIN_FIN_MUL, ST_SIN_ROUND, ST_TERM_MUL,
        ST_DIV_LOAD, ST_DIV_RUN, ST_POS_ADD, ST_ANG_SUB, ST_OUT_LOAD
    } state_t;

    typedef enum logic [1:0] {GL_RATE, GL_AMP, GL_PHASE} glide_t;

    state_t state_reg, state_next;
    glide_t gi_reg, gi_next;

    logic signed [shosc_pkg::AMP_W-1:0] tgt_amp_reg, tgt_amp_next;
    logic [shosc_pkg::RATE_W-1:0]       tgt_rate_reg, tgt_rate_next;
    logic [shosc_pkg::PHASE_W-1:0]      tgt_phase_reg, tgt_phase_next;
    logic [shosc_pkg::COUNT_W-1:0]      harm_count_reg, harm_count_next;

    logic [31:0]        srate_reg, srate_next;
    logic signed [31:0] samp_reg, samp_next;
    logic [31:0]        sphase_reg, sphase_next;
    logic [31:0]        acc_reg, acc_next;

    logic [shosc_pkg::STEP_W-1:0] dt_reg, dt_next;
    logic [31:0]        x_reg, x_next;
    logic               neg_reg, neg_next;
    logic [25:0]        q_reg, q_next;
    logic signed [65:0] prod_reg, prod_next;
    logic [31:0]        ang_reg, ang_next;
    logic [HB-1:0]      h_reg, h_next;
    logic               sel_reg, sel_next;
    logic               quad_hi_reg, quad_hi_next;
    logic [30:0]        u_reg, u_next;
    logic [30:0]        u2_reg, u2_next;
    logic signed [31:0] p_reg, p_next;
    logic [1:0]         k_reg, k_next;
    logic signed [15:0] s_reg, s_next;
    logic signed [SUM_W-1:0] pos_sum_reg, pos_sum_next;
    logic signed [SUM_W-1:0] ang_sum_reg, ang_sum_next;
    logic [DIV_W-1:0]   div_num_reg, div_num_next;
    logic [HB:0]        div_rem_reg, div_rem_next;
    logic               div_sign_reg, div_sign_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]   m_pos_reg, m_pos_next;
    logic [OUT_W-1:0]   m_ang_reg, m_ang_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [33:0] g_tgt, g_val, g_diff, g_mag;
    logic [HB-1:0]      count_eff;
    logic [HB:0]        rem_step;
    logic [DIV_W-1:0]   num_step;
    logic [25:0]        q0;
    logic [32:0]        q0_x100, g_rem;
    logic [31:0]        g_delta;
    logic [1:0]         quad;
    logic [29:0]        frac;
    logic signed [32:0] s_wide;
    logic signed [15:0] s_val;
    logic signed [65:0] prod_mag;
    logic signed [SUM_W-1:0] q_ext;

    function automatic logic [OUT_W-1:0] sat_round(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0] v;
        logic signed [SUM_W-1:0] r;
        v = sum + SUM_W'(shosc_pkg::ROUND_HALF);
        r = v >>> shosc_pkg::ROUND_SHIFT;
        if (r > SUM_W'(shosc_pkg::OUT_MAX)) begin
            r = SUM_W'(shosc_pkg::OUT_MAX);
        end else if (r < SUM_W'(shosc_pkg::OUT_MIN)) begin
            r = SUM_W'(shosc_pkg::OUT_MIN);
        end
        return r[OUT_W-1:0];
    endfunction

    assign s_ready    = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_position = m_pos_reg;
    assign m_angle    = m_ang_reg;

    always_comb begin
        if (32'(harm_count_reg) > 32'(HARMONICS_MAX)) begin
            count_eff = HB'(HARMONICS_MAX);
        end else begin
            count_eff = HB'(harm_count_reg);
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_GLIDE_MUL: begin
                mul_a = {1'b0, x_reg};
                mul_b = {1'b0, shosc_pkg::GLIDE_RECIP};
            end
            ST_ACC_MUL: begin
                mul_a = {1'b0, srate_reg};
                mul_b = {17'd0, dt_reg};
            end
            ST_SIN_SQ: begin
                mul_a = {2'b00, u_reg};
                mul_b = {2'b00, u_reg};
            end
            ST_POLY_MUL: begin
                mul_a = {2'b00, u2_reg};
                mul_b = {p_reg[31], p_reg};
            end
            ST_SIN_FIN_MUL: begin
                mul_a = {2'b00, u_reg};
                mul_b = {p_reg[31], p_reg};
            end
            ST_TERM_MUL: begin
                mul_a = {samp_reg[31], samp_reg};
                mul_b = {{17{s_reg[15]}}, s_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // glide operands
    always_comb begin
        unique case (gi_reg)
            GL_RATE: begin
                g_tgt = {2'b00, tgt_rate_reg, 16'h0000};
                g_val = {2'b00, srate_reg};
            end
            GL_AMP: begin
                g_tgt = {{2{tgt_amp_reg[15]}}, tgt_amp_reg, 16'h0000};
                g_val = {{2{samp_reg[31]}}, samp_reg};
            end
            GL_PHASE: begin
                g_tgt = {2'b00, tgt_phase_reg, 16'h0000};
                g_val = {2'b00, sphase_reg};
            end
            default: begin
                g_tgt = '0;
                g_val = '0;
            end
        endcase
        g_diff  = g_tgt - g_val;
        g_mag   = g_diff[33] ? -g_diff : g_diff;
        q0      = prod_reg[63:38];
        q0_x100 = 33'(q0) * 33'(shosc_pkg::GLIDE_DIV);
        g_rem   = {1'b0, x_reg} - q0_x100;
        g_delta = neg_reg ? -{6'd0, q_reg} : {6'd0, q_reg};
    end

    // sine front end and rounding
    always_comb begin
        quad   = ang_reg[31:30] + {1'b0, sel_reg};
        frac   = {ang_reg[29 -: (SINE_TABLE_BITS - 2)], {(32 - SINE_TABLE_BITS){1'b0}}};
        s_wide = {prod_reg[61], prod_reg[61:30]} + 33'sd32768;
        s_val  = s_wide[31:16];
    end

    // divider digit: four restoring steps per cycle
    always_comb begin
        rem_step = div_rem_reg;
        num_step = div_num_reg;
        for (int i = 0; i < shosc_pkg::DIV_DIGIT; i++) begin
            rem_step = {rem_step[HB-1:0], num_step[DIV_W-1]};
            num_step = {num_step[DIV_W-2:0], 1'b0};
            if (rem_step >= {1'b0, h_reg}) begin
                rem_step    = rem_step - {1'b0, h_reg};
                num_step[0] = 1'b1;
            end
        end
        prod_mag = prod_reg[65] ? -prod_reg : prod_reg;
        q_ext    = SUM_W'(div_num_reg);
    end

    always_comb begin
        state_next      = state_reg;
        gi_next         = gi_reg;
        tgt_amp_next    = tgt_amp_reg;
        tgt_rate_next   = tgt_rate_reg;
        tgt_phase_next  = tgt_phase_reg;
        harm_count_next = harm_count_reg;
        srate_next      = srate_reg;
        samp_next       = samp_reg;
        sphase_next     = sphase_reg;
        acc_next        = acc_reg;
        dt_next         = dt_reg;
        x_next          = x_reg;
        neg_next        = neg_reg;
        q_next          = q_reg;
        prod_next       = mul_p;
        ang_next        = ang_reg;
        h_next          = h_reg;
        sel_next        = sel_reg;
        quad_hi_next    = quad_hi_reg;
        u_next          = u_reg;
        u2_next         = u2_reg;
        p_next          = p_reg;
        k_next          = k_reg;
        s_next          = s_reg;
        pos_sum_next    = pos_sum_reg;
        ang_sum_next    = ang_sum_reg;
        div_num_next    = div_num_reg;
        div_rem_next    = div_rem_reg;
        div_sign_next   = div_sign_reg;
        div_cnt_next    = div_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_pos_next      = m_pos_reg;
        m_ang_next      = m_ang_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                shosc_pkg::CFG_TARGET_AMPLITUDE: tgt_amp_next    = cfg_data;
                shosc_pkg::CFG_TARGET_RATE:      tgt_rate_next   = cfg_data;
                shosc_pkg::CFG_TARGET_PHASE:     tgt_phase_next  = cfg_data;
                shosc_pkg::CFG_HARMONIC_COUNT:   harm_count_next = cfg_data[4:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind == shosc_pkg::KIND_PRESET) begin
                        acc_next = {s_preset_angle, 16'h0000};
                    end else begin
                        dt_next    = s_time_step;
                        gi_next    = GL_RATE;
                        state_next = ST_GLIDE_DIFF;
                    end
                end
            end
            ST_GLIDE_DIFF: begin
                x_next     = g_mag[31:0];
                neg_next   = g_diff[33];
                state_next = ST_GLIDE_MUL;
            end
            ST_GLIDE_MUL: begin
                state_next = ST_GLIDE_FIX;
            end
            ST_GLIDE_FIX: begin
                q_next     = (g_rem >= 33'(shosc_pkg::GLIDE_DIV)) ? q0 + 26'd1 : q0;
                state_next = ST_GLIDE_APPLY;
            end
            ST_GLIDE_APPLY: begin
                case (gi_reg)
                    GL_RATE: begin
                        srate_next = srate_reg + g_delta;
                        gi_next    = GL_AMP;
                        state_next = ST_GLIDE_DIFF;
                    end
                    GL_AMP: begin
                        samp_next  = samp_reg + $signed(g_delta);
                        gi_next    = GL_PHASE;
                        state_next = ST_GLIDE_DIFF;
                    end
                    default: begin
                        sphase_next = sphase_reg + g_delta;
                        state_next  = ST_ACC_MUL;
                    end
                endcase
            end
            ST_ACC_MUL: begin
                state_next = ST_ACC_ADD;
            end
            ST_ACC_ADD: begin
                acc_next   = acc_reg + prod_reg[39:8];
                state_next = ST_HARM_INIT;
            end
            ST_HARM_INIT: begin
                ang_next     = sphase_reg + acc_reg;
                h_next       = HB'(1);
                sel_next     = 1'b0;
                pos_sum_next = '0;
                ang_sum_next = '0;
                state_next   = (count_eff == '0) ? ST_OUT_LOAD : ST_SIN_SETUP;
            end
            ST_SIN_SETUP: begin
                quad_hi_next = quad[1];
                u_next       = quad[0] ? shosc_pkg::Q30_ONE - {1'b0, frac} : {1'b0, frac};
                state_next   = ST_SIN_SQ;
            end
            ST_SIN_SQ: begin
                p_next     = shosc_pkg::POLY_C9;
                k_next     = 2'd0;
                state_next = ST_SIN_U2;
            end
            ST_SIN_U2: begin
                u2_next    = prod_reg[60:30];
                state_next = ST_POLY_MUL;
            end
            ST_POLY_MUL: begin
                state_next = ST_POLY_SUB;
            end
            ST_POLY_SUB: begin
                p_next     = shosc_pkg::poly_coef(k_reg) - prod_reg[61:30];
                k_next     = k_reg + 2'd1;
                state_next = (k_reg == 2'd3) ? ST_SIN_FIN_MUL : ST_POLY_MUL;
            end
            ST_SIN_FIN_MUL: begin
                state_next = ST_SIN_ROUND;
            end
            ST_SIN_ROUND: begin
                s_next     = quad_hi_reg ? -s_val : s_val;
                state_next = ST_TERM_MUL;
            end
            ST_TERM_MUL: begin
                state_next = sel_reg ? ST_ANG_SUB : ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                div_num_next  = prod_mag[DIV_W-1:0];
                div_sign_next = prod_reg[65];
                div_rem_next  = '0;
                div_cnt_next  = '0;
                state_next    = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                div_num_next = num_step;
                div_rem_next = rem_step;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_POS_ADD;
                end
            end
            ST_POS_ADD: begin
                pos_sum_next = div_sign_reg ? pos_sum_reg - q_ext : pos_sum_reg + q_ext;
                sel_next     = 1'b1;
                state_next   = ST_SIN_SETUP;
            end
            ST_ANG_SUB: begin
                ang_sum_next = ang_sum_reg - SUM_W'(prod_reg);
                if (h_reg == count_eff) begin
                    state_next = ST_OUT_LOAD;
                end else begin
                    h_next     = h_reg + HB'(1);
                    ang_next   = ang_reg + acc_reg;
                    sel_next   = 1'b0;
                    state_next = ST_SIN_SETUP;
                end
            end
            ST_OUT_LOAD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_pos_next   = sat_round(pos_sum_reg);
                    m_ang_next   = sat_round(ang_sum_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            tgt_amp_reg    <= '0;
            tgt_rate_reg   <= shosc_pkg::RATE_RESET;
            tgt_phase_reg  <= '0;
            harm_count_reg <= shosc_pkg::COUNT_RESET;
            srate_reg      <= shosc_pkg::SRATE_RESET;
            samp_reg       <= '0;
            sphase_reg     <= '0;
            acc_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            tgt_amp_reg    <= tgt_amp_next;
            tgt_rate_reg   <= tgt_rate_next;
            tgt_phase_reg  <= tgt_phase_next;
            harm_count_reg <= harm_count_next;
            srate_reg      <= srate_next;
            samp_reg       <= samp_next;
            sphase_reg     <= sphase_next;
            acc_reg        <= acc_next;
        end
        gi_reg       <= gi_next;
        dt_reg       <= dt_next;
        x_reg        <= x_next;
        neg_reg      <= neg_next;
        q_reg        <= q_next;
        prod_reg     <= prod_next;
        ang_reg      <= ang_next;
        h_reg        <= h_next;
        sel_reg      <= sel_next;
        quad_hi_reg  <= quad_hi_next;
        u_reg        <= u_next;
        u2_reg       <= u2_next;
        p_reg        <= p_next;
        k_reg        <= k_next;
        s_reg        <= s_next;
        pos_sum_reg  <= pos_sum_next;
        ang_sum_reg  <= ang_sum_next;
        div_num_reg  <= div_num_next;
        div_rem_reg  <= div_rem_next;
        div_sign_reg <= div_sign_next;
        div_cnt_reg  <= div_cnt_next;
        m_pos_reg    <= m_pos_next;
        m_ang_reg    <= m_ang_next;
    end

endmodule

>>> sv/shosc_checker.sv
// Port-level checks for the oscillator core, bound to the top level.
module shosc_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               s_kind,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [shosc_pkg::OUT_W-1:0]        m_position,
    input logic [shosc_pkg::OUT_W-1:0]        m_angle
);

    // a tick word holds off the input side while it is worked on
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind == shosc_pkg::KIND_TICK) |=> !s_ready)
        else $error("input ready right after a tick word");

    // a preset word produces no result word
    a_preset_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind == shosc_pkg::KIND_PRESET && !m_valid) |=> !m_valid)
        else $error("result word after a preset word");

    // a result word appears only as a tick finishes, and the input side reopens with it
    a_result_at_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (s_ready && !$past(s_ready)))
        else $error("result word outside the end of a tick");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_position) && $stable(m_angle)))
        else $error("result word changed while stalled");

endmodule

bind smoothed_harmonic_oscillator_core shosc_checker u_shosc_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_kind     (s_kind),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_position (m_position),
    .m_angle    (m_angle)
);

>>> test/smoothed_harmonic_oscillator_core_test.sv
// Self-checking testbench for the smoothed harmonic oscillator core, with its own prediction.
`timescale 1ns / 1ps

module smoothed_harmonic_oscillator_core_test;
    import shosc_pkg::*;

    localparam int HMAX           = HARMONICS_MAX_DEF;
    localparam int SINE_BITS      = SINE_TABLE_BITS_DEF;
    localparam int SETTLE_CYCLES  = 16 + 44 * HMAX + 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int HOLD_PERIOD    = 50000;
    localparam int HOLD_OFFSET    = 20000;
    localparam int HOLD_CYCLES    = 4000;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 4'hF;

    typedef enum logic [1:0] {ROW_TICK, ROW_PRESET, ROW_REG} row_op_t;
    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

    typedef struct packed {
        row_op_t                  op;
        logic [CFG_INDEX_W-1:0]   idx;
        logic [15:0]              val;
        logic                     lit;
        logic signed [OUT_W-1:0]  lit_pos;
        logic signed [OUT_W-1:0]  lit_ang;
    } stim_row_t;

    typedef struct {
        logic signed [OUT_W-1:0] pos;
        logic signed [OUT_W-1:0] ang;
    } q12_pair_t;

    typedef struct {
        logic                    lit;
        logic signed [OUT_W-1:0] pos;
        logic signed [OUT_W-1:0] ang;
    } word_tag_t;

    localparam int N_ROWS = 26;
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{ROW_TICK,   CFG_UNUSED,           16'h0000, 1'b1, 24'sd0, 24'sd0},
        '{ROW_TICK,   CFG_UNUSED,           16'hFFFF, 1'b1, 24'sd0, 24'sd0},
        '{ROW_PRESET, CFG_UNUSED,           16'hFFFF, 1'b0, 24'sd0, 24'sd0},
        '{ROW_TICK,   CFG_UNUSED,           16'h1234, 1'b1, 24'sd0, 24'sd0},
        '{ROW_REG,    CFG_UNUSED,           16'hFFFF, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG,    CFG_TARGET_AMPLITUDE, 16'h7FFF, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG,    CFG_TARGET_RATE,      16'hFFFF, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG,    CFG_TARGET_PHASE,     16'hFFFF, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG,    CFG_HARMONIC_COUNT,   16'h0000, 1'b0, 24'sd0, 24'sd0},
        '{ROW_TICK,   CFG_UNUSED,           16'hFFFF, 1'b1, 24'sd0, 24'sd0},
        '{ROW_REG,    CFG_HARMONIC_COUNT,   16'h0010, 1'b0, 24'sd0, 24'sd0},
        '{ROW_TICK,   CFG_UNUSED,           16'h0000, 1'b0, 24'sd0, 24'sd0},
        '{ROW_TICK,   CFG_UNUSED,           16'hFFFF, 1'b0, 24'sd0, 24'sd0},
        '{ROW_TICK,   CFG_UNUSED,           16'h0001, 1'b0, 24'sd0, 24'sd0},
        '{ROW_PRESET, CFG_UNUSED,           16'h0000, 1'b0, 24'sd0, 24'sd0},
        '{ROW_TICK,   CFG_UNUSED,           16'h8000, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG,    CFG_TARGET_AMPLITUDE, 16'h8000, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG,    CFG_TARGET_RATE,      16'h0000, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG,    CFG_TARGET_PHASE,     16'h0000, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG,    CFG_HARMONIC_COUNT,   16'hFFFF, 1'b0, 24'sd0, 24'sd0},
        '{ROW_TICK,   CFG_UNUSED,           16'hFFFF, 1'b0, 24'sd0, 24'sd0},
        '{ROW_PRESET, CFG_UNUSED,           16'h8000, 1'b0, 24'sd0, 24'sd0},
        '{ROW_TICK,   CFG_UNUSED,           16'h7FFF, 1'b0, 24'sd0, 24'sd0},
        '{ROW_REG,    CFG_HARMONIC_COUNT,   16'h0001, 1'b0, 24'sd0, 24'sd0},
        '{ROW_TICK,   CFG_UNUSED,           16'h0100, 1'b0, 24'sd0, 24'sd0},
        '{ROW_TICK,   CFG_UNUSED,           16'hFFFF, 1'b0, 24'sd0, 24'sd0}
    };

    localparam logic [CFG_INDEX_W-1:0] REG_CODES [4] = '{
        CFG_TARGET_AMPLITUDE, CFG_TARGET_RATE, CFG_TARGET_PHASE, CFG_HARMONIC_COUNT
    };

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic                    s_kind         = KIND_TICK;
    logic [STEP_W-1:0]       s_time_step    = '0;
    logic [STEP_W-1:0]       s_preset_angle = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic signed [OUT_W-1:0] m_position;
    logic signed [OUT_W-1:0] m_angle;
    logic                    cfg_valid      = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0]   cfg_data       = '0;

    smoothed_harmonic_oscillator_core #(
        .HARMONICS_MAX   (HMAX),
        .SINE_TABLE_BITS (SINE_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_time_step    (s_time_step),
        .s_preset_angle (s_preset_angle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_position     (m_position),
        .m_angle        (m_angle),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // oscillator state as the block should hold it
    logic signed [15:0] tgt_amp;
    logic [15:0]        tgt_rate;
    logic [15:0]        tgt_phase;
    logic [4:0]         hcount;
    logic [31:0]        srate;
    logic signed [31:0] samp;
    logic [31:0]        sphase;
    logic [31:0]        acc;

    q12_pair_t expected_outputs [$];
    word_tag_t word_tags [$];
    int        failures     = 0;
    int        quiet_cycles = 0;
    int        burst_left   = 0;

    function automatic longint sin_turn(input logic [31:0] ang);
        logic [31:0] a;
        longint      frac, u, u2, p, s;
        a    = (ang >> (32 - SINE_BITS)) << (32 - SINE_BITS);
        frac = {34'd0, a[29:0]};
        u    = a[30] ? (64'sd1073741824 - frac) : frac;
        u2   = (u * u) >>> 30;
        p    = longint'(POLY_C9);
        p    = longint'(POLY_C7) - ((u2 * p) >>> 30);
        p    = longint'(POLY_C5) - ((u2 * p) >>> 30);
        p    = longint'(POLY_C3) - ((u2 * p) >>> 30);
        p    = longint'(POLY_C1) - ((u2 * p) >>> 30);
        s    = (u * p) >>> 30;
        s    = (s + 64'sd32768) >>> 16;
        return a[31] ? -s : s;
    endfunction

    function automatic longint glide_to(input longint v, input longint t);
        return v + (t - v) / 64'sd100;
    endfunction

    function automatic logic signed [OUT_W-1:0] to_q12(input longint sum);
        longint r;
        r = (sum + 64'sd536870912) >>> 30;
        if (r > OUT_MAX) r = OUT_MAX;
        if (r < OUT_MIN) r = OUT_MIN;
        return r[OUT_W-1:0];
    endfunction

    function automatic void reset_oscillator();
        tgt_amp   = '0;
        tgt_rate  = RATE_RESET;
        tgt_phase = '0;
        hcount    = COUNT_RESET;
        srate     = SRATE_RESET;
        samp      = '0;
        sphase    = '0;
        acc       = '0;
    endfunction

    function automatic void load_target(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_TARGET_AMPLITUDE: tgt_amp   = data;
            CFG_TARGET_RATE:      tgt_rate  = data;
            CFG_TARGET_PHASE:     tgt_phase = data;
            CFG_HARMONIC_COUNT:   hcount    = data[4:0];
            default: ;
        endcase
    endfunction

    function automatic void advance_tick(input logic [15:0] dt,
                                         output logic signed [OUT_W-1:0] pos,
                                         output logic signed [OUT_W-1:0] ang);
        logic [63:0] prod, hacc;
        logic [31:0] a;
        longint      amp, psum, asum, s, c;
        int          cnt;
        srate  = 32'(glide_to({32'd0, srate}, {32'd0, tgt_rate, 16'h0000}));
        samp   = 32'(glide_to(longint'(samp), longint'(tgt_amp) * 64'sd65536));
        sphase = 32'(glide_to({32'd0, sphase}, {32'd0, tgt_phase, 16'h0000}));
        prod   = {32'd0, srate} * {48'd0, dt};
        acc    = acc + prod[39:8];
        cnt    = (hcount > HMAX) ? HMAX : int'(hcount);
        amp    = longint'(samp);
        psum   = 0;
        asum   = 0;
        for (int h = 1; h <= cnt; h++) begin
            hacc = 64'(h) * {32'd0, acc};
            a    = hacc[31:0] + sphase;
            s    = sin_turn(a);
            c    = sin_turn(a + 32'h4000_0000);
            psum = psum + (amp * s) / longint'(h);
            asum = asum - amp * c;
        end
        pos = to_q12(psum);
        ang = to_q12(asum);
    endfunction

    // predict on every accepted word, check every result word, watch for a hang
    logic      progress;
    word_tag_t tag;
    q12_pair_t pred, want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_oscillator();
            quiet_cycles = 0;
        end else begin
            progress = 1'b0;
            if (cfg_valid && cfg_ready) begin
                load_target(cfg_index, cfg_data);
                progress = 1'b1;
            end
            if (s_valid && s_ready) begin
                progress = 1'b1;
                if (word_tags.size() != 0) begin
                    tag = word_tags.pop_front();
                end else begin
                    tag.lit = 1'b0;
                end
                if (s_kind == KIND_PRESET) begin
                    acc = {s_preset_angle, 16'h0000};
                end else begin
                    advance_tick(s_time_step, pred.pos, pred.ang);
                    if (tag.lit) begin
                        pred.pos = tag.pos;
                        pred.ang = tag.ang;
                    end
                    expected_outputs.push_back(pred);
                end
            end
            if (m_valid && m_ready) begin
                progress = 1'b1;
                if (expected_outputs.size() == 0) begin
                    $error("result word with no tick pending");
                    failures++;
                end else begin
                    want = expected_outputs.pop_front();
                    if (m_position !== want.pos) begin
                        $error("position: expected %0d, got %0d", want.pos, m_position);
                        failures++;
                    end
                    if (m_angle !== want.ang) begin
                        $error("angle: expected %0d, got %0d", want.ang, m_angle);
                        failures++;
                    end
                end
            end
            if (progress) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int       rx_cycles;
        int       hold_left;
        int       mode_left;
        rx_mode_t mode;
        rx_cycles = 0;
        hold_left = 0;
        mode_left = 0;
        mode      = RX_OPEN;
        forever begin
            @(posedge aclk);
            rx_cycles++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_cycles % HOLD_PERIOD == HOLD_OFFSET) begin
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(1, 200);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
                    default:   m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic send_word(input logic kind, input logic [15:0] dt, input logic [15:0] pa,
                             input logic lit, input logic signed [OUT_W-1:0] lpos,
                             input logic signed [OUT_W-1:0] lang);
        int        gap;
        word_tag_t t;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) gap = 0;
            else if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 60);
            else gap = $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        t.lit = lit;
        t.pos = lpos;
        t.ang = lang;
        word_tags.push_back(t);
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_time_step    <= dt;
        s_preset_angle <= pa;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // drop valid, drain pending results, then let any trailing preset finish
    task automatic quiesce();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (expected_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_target();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_count();
        int         r;
        logic [4:0] cnt;
        r = $urandom_range(0, 99);
        if (r < 6) cnt = 5'($urandom_range(16, 31));
        else if (r < 10) cnt = 5'd0;
        else cnt = 5'($urandom_range(1, 4));
        return {11'($urandom()), cnt};
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        stim_row_t              row;
        logic                   cfg_open;
        logic                   kind;
        logic [CFG_INDEX_W-1:0] code;
        logic [CFG_DATA_W-1:0]  data;
        int                     sent;
        int                     rot;
        int                     n;
        cfg_open = 1'b0;
        sent     = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.op == ROW_REG) begin
                if (!cfg_open) begin
                    quiesce();
                    cfg_open = 1'b1;
                end
                write_reg(row.idx, row.val);
            end else begin
                if (cfg_open) begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                if (row.op == ROW_PRESET) begin
                    send_word(KIND_PRESET, 16'($urandom()), row.val, row.lit,
                              row.lit_pos, row.lit_ang);
                end else begin
                    send_word(KIND_TICK, row.val, 16'($urandom()), row.lit,
                              row.lit_pos, row.lit_ang);
                end
            end
        end

        while (sent < RANDOM_ITEMS) begin
            quiesce();
            rot = $urandom_range(0, 3);
            for (int j = 0; j < 4; j++) begin
                code = REG_CODES[(rot + j) % 4];
                data = (code == CFG_HARMONIC_COUNT) ? pick_count() : pick_target();
                write_reg(code, data);
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(4'($urandom_range(CFG_HARMONIC_COUNT + 1, 15)), 16'($urandom()));
            end
            cfg_valid <= 1'b0;
            n = $urandom_range(20, 80);
            repeat (n) begin
                kind = ($urandom_range(0, 7) == 0) ? KIND_PRESET : KIND_TICK;
                send_word(kind, pick_step(), 16'($urandom()), 1'b0, '0, '0);
                sent++;
            end
        end

        quiesce();
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
